// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the deframer back end
// each macro expects clk and rst_n in scope of the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the clock cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/detfd_pkg.sv =====
// shared types and constants of the dle/etx frame deframer
// no dependencies
`default_nettype none

package detfd_pkg;

    localparam logic [7:0] SYM_DLE = 8'd16;
    localparam logic [7:0] SYM_ETX = 8'd3;
    localparam logic [8:0] POS_MAX = 9'd511;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        FS_HUNT,
        FS_BODY,
        FS_ESC
    } front_state_t;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_PAIR,
        OP_CLOSE
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    // command from the front to the back
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/detfd_front.sv =====
// front: hunts for the opening dle, undoes the escapes and classifies each item
// depends on detfd_pkg
`default_nettype none

module detfd_front
    import detfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            push,
    output cmd_t            push_cmd,
    input  wire logic       q_ready
);

    front_state_t state_reg, state_next;
    logic         take;

    assign in_ready = q_ready;
    assign take     = in_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        push          = 1'b0;
        push_cmd.op   = OP_DATA;
        push_cmd.data = in_byte;
        if (take)
        begin
            case (state_reg)
                FS_HUNT:
                begin
                    if (in_byte == SYM_DLE)
                        state_next = FS_BODY;
                end
                FS_BODY:
                begin
                    if (in_byte == SYM_DLE)
                        state_next = FS_ESC;
                    else
                        push = 1'b1;
                end
                FS_ESC:
                begin
                    push       = 1'b1;
                    state_next = FS_BODY;
                    if (in_byte == SYM_ETX)
                    begin
                        push_cmd.op = OP_CLOSE;
                        state_next  = FS_HUNT;
                    end
                    else if (in_byte != SYM_DLE)
                    begin
                        // dle then other byte gives both as data
                        push_cmd.op = OP_PAIR;
                    end
                end
                default:
                begin
                    state_next = FS_HUNT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/detfd_queue.sv =====
// short command queue between front and back
// depends on detfd_pkg
`default_nettype none

module detfd_queue
    import detfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      q_ready,
    output logic      q_valid,
    output cmd_t      q_cmd,
    input  wire logic pop
);

    cmd_t                mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCOUNT_W-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign q_ready = (count_reg != QCOUNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/detfd_back.sv =====
// back: tracks position, size and checksum and drives the result register
// depends on detfd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module detfd_back
    import detfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_byte,
    output logic [8:0]       out_position,
    output logic             out_last
);

    logic       valid_reg, valid_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic [8:0] pos_reg, pos_next;
    logic       last_reg, last_next;

    logic       phase_reg, phase_next;
    logic [8:0] index_reg, index_next;
    logic [7:0] size_reg, size_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] prev_reg, prev_next;

    logic       load;
    logic       first_of_pair;
    logic [7:0] cur_byte;
    logic       sum_en;
    logic       good;

    assign out_valid    = valid_reg;
    assign out_kind     = kind_reg;
    assign out_byte     = byte_reg;
    assign out_position = pos_reg;
    assign out_last     = last_reg;

    assign load          = q_valid && (!valid_reg || out_ready);
    assign first_of_pair = (q_cmd.op == OP_PAIR) && !phase_reg;
    assign cur_byte      = first_of_pair ? SYM_DLE : q_cmd.data;
    assign pop           = load && !first_of_pair;

    // id and size always count, then only the declared data bytes
    assign sum_en = (index_reg <= 9'd1) ||
                    ({1'b0, index_reg} < ({2'b0, size_reg} + 10'd2));
    assign good   = ({1'b0, index_reg} >= ({2'b0, size_reg} + 10'd3)) &&
                    (8'(sum_reg + prev_reg) == 8'd0);

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        phase_next = phase_reg;
        index_next = index_reg;
        size_next  = size_reg;
        sum_next   = sum_reg;
        prev_next  = prev_reg;
        if (load)
        begin
            valid_next = 1'b1;
            pos_next   = index_reg;
            if (q_cmd.op == OP_CLOSE)
            begin
                kind_next  = good ? KIND_GOOD : KIND_BAD;
                byte_next  = '0;
                last_next  = 1'b1;
                phase_next = 1'b0;
                index_next = '0;
                size_next  = '0;
                sum_next   = '0;
                prev_next  = '0;
            end
            else
            begin
                kind_next  = KIND_DATA;
                byte_next  = cur_byte;
                last_next  = !first_of_pair;
                phase_next = first_of_pair;
                if (index_reg == 9'd1)
                    size_next = cur_byte;
                if (sum_en)
                    sum_next = sum_reg + cur_byte;
                prev_next = cur_byte;
                if (index_reg != POS_MAX)
                    index_next = index_reg + 9'd1;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
            index_reg <= '0;
            size_reg  <= '0;
            sum_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
            index_reg <= index_next;
            size_reg  <= size_next;
            sum_reg   <= sum_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
    end

    `ASSERT_ALWAYS(a_phase_on_pair, !phase_reg || (q_valid && q_cmd.op == OP_PAIR), "phase set without pair at head")
    `ASSERT_NEXT(a_close_clears, load && q_cmd.op == OP_CLOSE, index_reg == 9'd0 && sum_reg == 8'd0 && !phase_reg, "close did not clear frame state")
    `ASSERT_ALWAYS(a_close_no_byte, !valid_reg || kind_reg == KIND_DATA || (byte_reg == 8'd0 && last_reg), "close result carries data")
    `ASSERT_NEXT(a_pair_first_not_last, load && first_of_pair, valid_reg && !last_reg && byte_reg == SYM_DLE, "pair first half wrong")

endmodule

`default_nettype wire

// ===== rtl/core/dle_etx_frame_deframer.sv =====
// top level of the dle/etx byte-stuffed frame deframer with checksum check
// depends on detfd_pkg, detfd_front, detfd_queue and detfd_back
//
//   channel   dir   tdata                               tuser       tlast
//   s_*       in    [7:0] rx_byte                       -           -
//   m_*       out   [7:0] byte_value, [16:8] position   [1:0] kind  last
//
// one input byte per cycle is taken while the two-entry command queue has room
// a dle followed by a plain byte yields two results from one queue entry
// results leave from a register, so the input keeps flowing while m_tready is low
// until the queue fills; reset is asynchronous, active low, and starts in hunt
`default_nettype none

module dle_etx_frame_deframer
    import detfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] byte_value, [16:8] position, [23:17] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast
);

    logic       push, q_ready, q_valid, pop;
    cmd_t       push_cmd, q_cmd;
    logic [7:0] out_byte;
    logic [8:0] out_position;

    detfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready)
    );

    detfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    detfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (m_tuser),
        .out_byte     (out_byte),
        .out_position (out_position),
        .out_last     (m_tlast)
    );

    assign m_tdata = {7'd0, out_position, out_byte};

endmodule

`default_nettype wire

// ===== tb/tb_dle_etx_frame_deframer.sv =====
// self-checking testbench for the dle/etx frame deframer
// depends on detfd_pkg and dle_etx_frame_deframer; a scoreboard class predicts each result
`default_nettype none

module tb_dle_etx_frame_deframer;
    import detfd_pkg::*;

    localparam int NUM_ITEMS    = 1300;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic [8:0] position;
        logic       last;
    } deframe_result_t;

    class deframe_checker;
        bit              in_frame;
        bit              esc_pending;
        logic [8:0]      byte_idx;
        logic [7:0]      size_field;
        logic [7:0]      frame_sum;
        logic [7:0]      prev_byte;
        deframe_result_t expected_q[$];
        int              errors;
        int              bytes_seen;
        int              results_seen;
        int              good_closes;
        int              bad_closes;

        function new();
            in_frame = 1'b0;
            clear_frame();
        endfunction

        function void clear_frame();
            esc_pending = 1'b0;
            byte_idx    = '0;
            size_field  = '0;
            frame_sum   = '0;
            prev_byte   = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_data(logic [7:0] b);
            deframe_result_t r;
            if (byte_idx == 9'd1)
                size_field = b;
            // id and size are always summed, then only the declared data bytes
            if (byte_idx <= 9'd1 || int'(byte_idx) < int'(size_field) + 2)
                frame_sum = frame_sum + b;
            prev_byte  = b;
            r.kind     = KIND_DATA;
            r.value    = b;
            r.position = byte_idx;
            r.last     = 1'b0;
            expected_q = {expected_q, r};
            if (byte_idx < POS_MAX)
                byte_idx = byte_idx + 9'd1;
        endfunction

        function void note_rx_byte(logic [7:0] b);
            deframe_result_t r;
            logic [7:0]      chk;
            int              prior_count;
            prior_count = expected_q.size();
            bytes_seen++;
            if (!in_frame) begin
                if (b == SYM_DLE) begin
                    in_frame = 1'b1;
                    clear_frame();
                end
            end
            else if (!esc_pending) begin
                if (b == SYM_DLE)
                    esc_pending = 1'b1;
                else
                    push_data(b);
            end
            else begin
                esc_pending = 1'b0;
                if (b == SYM_DLE) begin
                    push_data(SYM_DLE);
                end
                else if (b == SYM_ETX) begin
                    chk = frame_sum + prev_byte;
                    if (int'(byte_idx) >= int'(size_field) + 3 && chk == 8'd0) begin
                        r.kind = KIND_GOOD;
                        good_closes++;
                    end
                    else begin
                        r.kind = KIND_BAD;
                        bad_closes++;
                    end
                    r.value    = 8'd0;
                    r.position = byte_idx;
                    r.last     = 1'b0;
                    expected_q = {expected_q, r};
                    in_frame = 1'b0;
                    clear_frame();
                end
                else begin
                    // escape with a plain byte passes both through
                    push_data(SYM_DLE);
                    push_data(b);
                end
            end
            if (expected_q.size() > prior_count)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] value,
                                   logic [8:0] position, logic last);
            deframe_result_t e;
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind %0d value %0d position %0d last %0d",
                         $time, kind, value, position, last);
                return;
            end
            e = expected_q.pop_front();
            if (kind !== e.kind || value !== e.value || position !== e.position ||
                last !== e.last) begin
                errors++;
                $display("%0t: mismatch: expected kind %0d value %0d position %0d last %0d",
                         $time, e.kind, e.value, e.position, e.last);
                $display("%0t:           actual   kind %0d value %0d position %0d last %0d",
                         $time, kind, value, position, last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    deframe_checker rx_model;
    bit             no_gaps;
    bit             hold_off_req;
    int             items_sent;
    int             idle_cycles;

    dle_etx_frame_deframer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r < 2)
            return SYM_DLE;
        if (r == 2)
            return SYM_ETX;
        return 8'($urandom_range(0, 255));
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (rx_model.pending() != 0)
            @(negedge clk);
    endtask

    // id, size, data, extra bytes and checksum, stuffed and wrapped in dle ... dle etx
    task automatic send_frame(input int size, input int extra, input bit corrupt,
                              input bit cut_short);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] chk;
        int         keep;
        body = {body, rand_byte()};
        body = {body, size[7:0]};
        repeat (size) body = {body, rand_byte()};
        sum = 8'd0;
        foreach (body[i])
            sum = sum + body[i];
        repeat (extra) body = {body, rand_byte()};
        chk = -sum;
        if (corrupt)
            chk = chk ^ 8'($urandom_range(1, 255));
        body = {body, chk};
        if (cut_short)
        begin
            keep = $urandom_range(0, body.size() - 1);
            while (body.size() > keep)
                void'(body.pop_back());
        end
        send_byte(SYM_DLE);
        foreach (body[i])
        begin
            if (body[i] == SYM_DLE)
                send_byte(SYM_DLE);
            send_byte(body[i]);
        end
        send_byte(SYM_DLE);
        send_byte(SYM_ETX);
    endtask

    // receiver with random stalls, steady stretches and one long hold-off
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            stall = gap_len();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // input items are noted before results of the same edge are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                rx_model.note_rx_byte(s_tdata);
            if (m_tvalid && m_tready)
                rx_model.check_result(m_tuser, m_tdata[7:0], m_tdata[16:8], m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        int frame_no;
        int pick;
        int n;
        rx_model     = new();
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        no_gaps      = 1'b0;
        hold_off_req = 1'b0;
        items_sent   = 0;
        idle_cycles  = 0;
        frame_no     = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // bytes dropped while hunting, etx among them
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYM_ETX);
        // empty frame
        send_byte(SYM_DLE);
        send_byte(SYM_DLE);
        send_byte(SYM_ETX);
        // minimal good frame: id 1, size 0, checksum ff
        send_byte(SYM_DLE);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYM_DLE);
        send_byte(SYM_ETX);
        // dle then plain byte gives two items, frame ends short
        send_byte(SYM_DLE);
        send_byte(8'h20);
        send_byte(SYM_DLE);
        send_byte(8'h41);
        send_byte(SYM_DLE);
        send_byte(SYM_ETX);
        // stuffed dle as data, one trailing byte past the data, good checksum
        send_byte(SYM_DLE);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(SYM_DLE);
        send_byte(SYM_DLE);
        send_byte(8'h77);
        send_byte(8'hF0);
        send_byte(SYM_DLE);
        send_byte(SYM_ETX);

        while (items_sent < NUM_ITEMS)
        begin
            frame_no++;
            pick    = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 5) == 0);
            if (frame_no == 4)
            begin
                // receiver stalls while the sender keeps pushing
                hold_off_req = 1'b1;
                no_gaps      = 1'b1;
                send_frame(30, 0, 1'b0, 1'b0);
            end
            else if (frame_no == 8)
            begin
                // runs the position counter past its saturation point
                send_frame(255, 300, 1'b0, 1'b0);
            end
            else if (frame_no % 40 == 0)
            begin
                pause_sender();
            end
            else if (pick < 70)
            begin
                n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
                send_frame(n, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0,
                           $urandom_range(0, 99) < 15, 1'b0);
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 90)
            begin
                send_byte(SYM_DLE);
                repeat ($urandom_range(0, 6)) send_byte(rand_byte());
                if ($urandom_range(0, 1) == 1)
                begin
                    send_byte(SYM_DLE);
                    send_byte(SYM_ETX);
                end
            end
            else
            begin
                send_frame($urandom_range(1, 12), 0, 1'b0, 1'b1);
            end
            no_gaps = 1'b0;
        end

        pause_sender();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d raw bytes through the deframer, checked %0d results",
                 rx_model.bytes_seen, rx_model.results_seen);
        $display("frames closed: %0d with good checksum, %0d with bad or short",
                 rx_model.good_closes, rx_model.bad_closes);
        if (rx_model.errors == 0 && rx_model.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
